>>> hdl/grid_astar_path_search_macros.svh
// Assertion helpers, clocked on i_clk, disabled while in reset.
`ifndef GRID_ASTAR_PATH_SEARCH_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_MACROS_SVH

// Same-cycle implication.
`define GAPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GAPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/gaps_pkg.sv
package gaps_pkg;

    // cell states
    localparam logic [2:0] ST_EMPTY    = 3'd0;
    localparam logic [2:0] ST_OBSTACLE = 3'd1;
    localparam logic [2:0] ST_CLOSED   = 3'd2;
    localparam logic [2:0] ST_PATH     = 3'd3;
    localparam logic [2:0] ST_START    = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    // config register indexes
    localparam logic [2:0] CFG_ROWS      = 3'd0;
    localparam logic [2:0] CFG_COLS      = 3'd1;
    localparam logic [2:0] CFG_START_ROW = 3'd2;
    localparam logic [2:0] CFG_START_COL = 3'd3;
    localparam logic [2:0] CFG_GOAL_ROW  = 3'd4;
    localparam logic [2:0] CFG_GOAL_COL  = 3'd5;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    // neighbor offsets, 4-bit two's complement: up, left, down, right
    localparam logic [3:0] MV_DR [4] = '{4'hF, 4'h0, 4'h1, 4'h0};
    localparam logic [3:0] MV_DC [4] = '{4'h0, 4'hF, 4'h0, 4'h1};

    typedef enum logic [3:0] {
        S_IDLE,
        S_COPY,
        S_SEED,
        S_SCAN_INIT,
        S_SCAN,
        S_POP,
        S_NB_RD,
        S_NB_CHK,
        S_MARK_S,
        S_MARK_G,
        S_EM_RD,
        S_EM_LD,
        S_NOTFOUND
    } t_state;

endpackage

>>> hdl/grid_astar_path_search.sv
// Grid A* path search. Load words (mode 0) write the obstacle bit of one cell;
// a run word (mode 1) searches from the start cell to the goal cell with
// four-neighbor moves and a Manhattan heuristic, then streams every used cell
// in row-major order (found=1, last on the final cell) or one not-found word.
// Steps of a run: a copy sweep of every cell into the working map, then
// per popped cell a scan of the open list (one open-list memory read per
// pushed slot) and up to four neighbor checks, then one read and one
// load per emitted cell, held while the sink stalls. The open-list scan
// through the single read port dominates the run time. Load words do not
// leave the idle state. One word is worked at a time; the input is ready
// only while the search engine is idle.
`include "grid_astar_path_search_macros.svh"

module grid_astar_path_search import gaps_pkg::*; #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config write port
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_addr,
    input  logic [3:0] i_cfg_wdata,
    // input words
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_mode,
    input  logic [2:0] i_cell_row,
    input  logic [2:0] i_cell_col,
    input  logic       i_cell_blocked,
    // result words
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_found,
    output logic [2:0] o_cell_state,
    output logic [2:0] o_out_row,
    output logic [2:0] o_out_col,
    output logic       o_last
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int CI_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int G_W   = CI_W;
    localparam int F_W   = ((CI_W > 4) ? CI_W : 4) + 1;
    // open entry: {row, col, g, h}
    localparam int OE_W  = 3 + 3 + G_W + 4;
    localparam logic [CI_W:0] CELLS_C = (CI_W + 1)'(CELLS);

    function automatic logic [CI_W-1:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
        int v;
        v = int'(r) * MAX_COLS + int'(c);
        return CI_W'(v);
    endfunction

    // config registers
    logic [3:0] r_rows, r_cols;
    logic [2:0] r_sr, r_sc, r_gr, r_gc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 4'd8;
            r_cols <= 4'd8;
            r_sr   <= 3'd0;
            r_sc   <= 3'd0;
            r_gr   <= 3'd0;
            r_gc   <= 3'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ROWS:      r_rows <= i_cfg_wdata;
                CFG_COLS:      r_cols <= i_cfg_wdata;
                CFG_START_ROW: r_sr   <= i_cfg_wdata[2:0];
                CFG_START_COL: r_sc   <= i_cfg_wdata[2:0];
                CFG_GOAL_ROW:  r_gr   <= i_cfg_wdata[2:0];
                CFG_GOAL_COL:  r_gc   <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // used grid size, saturated to the physical grid
    logic [3:0] rows_u, cols_u;
    assign rows_u = (r_rows > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : r_rows;
    assign cols_u = (r_cols > 4'(MAX_COLS)) ? 4'(MAX_COLS) : r_cols;

    function automatic logic [3:0] heur(input logic [2:0] r, input logic [2:0] c,
                                        input logic [2:0] gr, input logic [2:0] gc);
        logic [2:0] dr, dc;
        dr = (r > gr) ? r - gr : gr - r;
        dc = (c > gc) ? c - gc : gc - c;
        return {1'b0, dr} + {1'b0, dc};
    endfunction

    // ---------------- memories ----------------
    // obstacle map; valid bits stand for the all-free reset value
    logic              bm_mem [CELLS];
    logic [CELLS-1:0]  r_bvld;
    logic              bm_we, bm_re, bm_q;
    logic [CI_W-1:0]   bm_waddr, bm_raddr;

    // working map
    logic [2:0]        ws_mem [CELLS];
    logic              ws_we, ws_re;
    logic [CI_W-1:0]   ws_waddr, ws_raddr;
    logic [2:0]        ws_wdata, ws_q;

    // open list, append-only slots; valid bits mark entries not yet popped
    logic [OE_W-1:0]   om_mem [CELLS];
    logic [CELLS-1:0]  r_ovld;
    logic              om_we, om_re;
    logic [OE_W-1:0]   om_wdata, om_q;

    t_state            r_state, n_state;
    logic [CI_W:0]     r_ci, r_scan, r_push, r_cnt;
    logic              r_cp_go, r_cp_bv;
    logic [CI_W-1:0]   r_cp_addr;
    logic              r_p_go;
    logic [CI_W-1:0]   r_p_slot;
    logic              r_have;
    logic [2:0]        r_b_row, r_b_col;
    logic [G_W-1:0]    r_b_g;
    logic [F_W-1:0]    r_bf;
    logic [CI_W-1:0]   r_b_slot;
    logic [1:0]        r_k;
    logic [2:0]        r_er, r_ec;
    logic              r_ov, r_found, r_last;
    logic [2:0]        r_ostate, r_orow, r_ocol;

    always_ff @(posedge i_clk) begin
        if (bm_we) bm_mem[bm_waddr] <= i_cell_blocked;
        if (bm_re) bm_q <= bm_mem[bm_raddr];
        if (ws_we) ws_mem[ws_waddr] <= ws_wdata;
        if (ws_re) ws_q <= ws_mem[ws_raddr];
        if (om_we) om_mem[r_push[CI_W-1:0]] <= om_wdata;
        if (om_re) om_q <= om_mem[r_scan[CI_W-1:0]];
    end

    // ---------------- combinational control ----------------
    logic in_acc, out_free, ov_set, start_on, cp_issue, sc_issue, nb_in, em_last, at_goal;
    logic [3:0] nr4, nc4;
    logic [2:0] oq_row, oq_col;
    logic [G_W-1:0] oq_g;
    logic [3:0] oq_h;
    logic [F_W-1:0] oq_f;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_ov || i_out_ready;
    // a result word is loaded into the output register this cycle
    assign ov_set     = out_free && (r_state inside {S_EM_LD, S_NOTFOUND});
    assign start_on   = ({1'b0, r_sr} < rows_u) && ({1'b0, r_sc} < cols_u);
    assign cp_issue   = (r_ci < CELLS_C);
    assign sc_issue   = (r_scan < r_push);
    assign nr4        = {1'b0, r_b_row} + MV_DR[r_k];
    assign nc4        = {1'b0, r_b_col} + MV_DC[r_k];
    assign nb_in      = (nr4 < rows_u) && (nc4 < cols_u);
    assign em_last    = (({1'b0, r_er} + 4'd1) == rows_u) && (({1'b0, r_ec} + 4'd1) == cols_u);
    assign at_goal    = (r_b_row == r_gr) && (r_b_col == r_gc);
    assign {oq_row, oq_col, oq_g, oq_h} = om_q;
    assign oq_f       = F_W'(oq_g) + F_W'(oq_h);

    assign bm_we    = in_acc && (i_mode == MODE_LOAD) &&
                      (int'(i_cell_row) < MAX_ROWS) && (int'(i_cell_col) < MAX_COLS);
    assign bm_waddr = cell_idx(i_cell_row, i_cell_col);
    assign bm_re    = (r_state == S_COPY) && cp_issue;
    assign bm_raddr = r_ci[CI_W-1:0];
    assign om_re    = (r_state == S_SCAN) && sc_issue;

    always_comb begin
        n_state  = r_state;
        ws_we    = 1'b0;
        ws_waddr = cell_idx(r_b_row, r_b_col);
        ws_wdata = ST_PATH;
        ws_re    = 1'b0;
        ws_raddr = cell_idx(nr4[2:0], nc4[2:0]);
        om_we    = 1'b0;
        om_wdata = {nr4[2:0], nc4[2:0], r_b_g + G_W'(1), heur(nr4[2:0], nc4[2:0], r_gr, r_gc)};
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_mode == MODE_RUN) n_state = S_COPY;
            end
            S_COPY: begin
                ws_we    = r_cp_go;
                ws_waddr = r_cp_addr;
                ws_wdata = (bm_q && r_cp_bv) ? ST_OBSTACLE : ST_EMPTY;
                if (!cp_issue && !r_cp_go) n_state = S_SEED;
            end
            S_SEED: begin
                if (!start_on) begin
                    n_state = S_NOTFOUND;
                end else begin
                    om_we    = 1'b1;
                    om_wdata = {r_sr, r_sc, G_W'(0), heur(r_sr, r_sc, r_gr, r_gc)};
                    ws_we    = 1'b1;
                    ws_waddr = cell_idx(r_sr, r_sc);
                    ws_wdata = ST_CLOSED;
                    n_state  = S_SCAN_INIT;
                end
            end
            S_SCAN_INIT: begin
                n_state = (r_cnt == '0) ? S_NOTFOUND : S_SCAN;
            end
            S_SCAN: begin
                if (!sc_issue && !r_p_go) n_state = S_POP;
            end
            S_POP: begin
                ws_we   = 1'b1;
                n_state = at_goal ? S_MARK_S : S_NB_RD;
            end
            S_NB_RD: begin
                if (nb_in) begin
                    ws_re   = 1'b1;
                    n_state = S_NB_CHK;
                end else if (r_k == 2'd3) begin
                    n_state = S_SCAN_INIT;
                end
            end
            S_NB_CHK: begin
                if (ws_q == ST_EMPTY) begin
                    om_we    = 1'b1;
                    ws_we    = 1'b1;
                    ws_waddr = cell_idx(nr4[2:0], nc4[2:0]);
                    ws_wdata = ST_CLOSED;
                end
                n_state = (r_k == 2'd3) ? S_SCAN_INIT : S_NB_RD;
            end
            S_MARK_S: begin
                ws_we    = 1'b1;
                ws_waddr = cell_idx(r_sr, r_sc);
                ws_wdata = ST_START;
                n_state  = S_MARK_G;
            end
            S_MARK_G: begin
                ws_we    = 1'b1;
                ws_waddr = cell_idx(r_gr, r_gc);
                ws_wdata = ST_FINISH;
                n_state  = S_EM_RD;
            end
            S_EM_RD: begin
                ws_re    = 1'b1;
                ws_raddr = cell_idx(r_er, r_ec);
                n_state  = S_EM_LD;
            end
            S_EM_LD: begin
                if (out_free) n_state = em_last ? S_IDLE : S_EM_RD;
            end
            S_NOTFOUND: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // ---------------- datapath and counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld  <= '0;
            r_ovld  <= '0;
            r_push  <= '0;
            r_cnt   <= '0;
            r_ci    <= '0;
            r_scan  <= '0;
            r_cp_go <= 1'b0;
            r_p_go  <= 1'b0;
            r_have  <= 1'b0;
            r_k     <= '0;
            r_er    <= '0;
            r_ec    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (bm_we) r_bvld[bm_waddr] <= 1'b1;
            if (ov_set)           r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_mode == MODE_RUN) begin
                        r_ci    <= '0;
                        r_cp_go <= 1'b0;
                        r_ovld  <= '0;
                        r_push  <= '0;
                        r_cnt   <= '0;
                    end
                end
                S_COPY: begin
                    r_cp_go   <= cp_issue;
                    r_cp_addr <= r_ci[CI_W-1:0];
                    r_cp_bv   <= r_bvld[r_ci[CI_W-1:0]];
                    if (cp_issue) r_ci <= r_ci + 1'b1;
                end
                S_SEED: begin
                    if (start_on) begin
                        r_ovld[0] <= 1'b1;
                        r_push    <= (CI_W + 1)'(1);
                        r_cnt     <= (CI_W + 1)'(1);
                    end
                end
                S_SCAN_INIT: begin
                    r_scan <= '0;
                    r_have <= 1'b0;
                    r_p_go <= 1'b0;
                end
                S_SCAN: begin
                    r_p_go   <= sc_issue && r_ovld[r_scan[CI_W-1:0]];
                    r_p_slot <= r_scan[CI_W-1:0];
                    if (sc_issue) r_scan <= r_scan + 1'b1;
                    // ties go to the later slot, i.e. the newer entry
                    if (r_p_go && (!r_have || oq_f <= r_bf)) begin
                        r_have   <= 1'b1;
                        r_b_row  <= oq_row;
                        r_b_col  <= oq_col;
                        r_b_g    <= oq_g;
                        r_bf     <= oq_f;
                        r_b_slot <= r_p_slot;
                    end
                end
                S_POP: begin
                    r_ovld[r_b_slot] <= 1'b0;
                    r_cnt            <= r_cnt - 1'b1;
                    r_k              <= '0;
                end
                S_NB_RD: begin
                    if (!nb_in) r_k <= r_k + 1'b1;
                end
                S_NB_CHK: begin
                    r_k <= r_k + 1'b1;
                    if (ws_q == ST_EMPTY) begin
                        r_ovld[r_push[CI_W-1:0]] <= 1'b1;
                        r_push <= r_push + 1'b1;
                        r_cnt  <= r_cnt + 1'b1;
                    end
                end
                S_MARK_G: begin
                    r_er <= '0;
                    r_ec <= '0;
                end
                S_EM_LD: begin
                    if (out_free) begin
                        r_found  <= 1'b1;
                        r_ostate <= ws_q;
                        r_orow   <= r_er;
                        r_ocol   <= r_ec;
                        r_last   <= em_last;
                        if (({1'b0, r_ec} + 4'd1) == cols_u) begin
                            r_ec <= '0;
                            r_er <= r_er + 1'b1;
                        end else begin
                            r_ec <= r_ec + 1'b1;
                        end
                    end
                end
                S_NOTFOUND: begin
                    if (out_free) begin
                        r_found  <= 1'b0;
                        r_ostate <= ST_EMPTY;
                        r_orow   <= '0;
                        r_ocol   <= '0;
                        r_last   <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid  = r_ov;
    assign o_found      = r_found;
    assign o_cell_state = r_ostate;
    assign o_out_row    = r_orow;
    assign o_out_col    = r_ocol;
    assign o_last       = r_last;

    // ---------------- assertions ----------------
    `GAPS_ASSERT_NOW(a_cnt_le_push, 1'b1, r_cnt <= r_push, "open count above pushed slots")
    `GAPS_ASSERT_NOW(a_push_le_cells, 1'b1, r_push <= CELLS_C, "open list overflow")
    `GAPS_ASSERT_NOW(a_pop_has_best, r_state == S_POP, r_have && r_cnt != '0,
                     "pop without an open entry")
    `GAPS_ASSERT_NEXT(a_load_idle, in_acc && i_mode == MODE_LOAD, r_state == S_IDLE,
                      "load word left the idle state")

endmodule
